// ===== rtl/i2a_pkg.sv =====
// integer to ascii converter package: widths, codes, queue entry type
// and the digit to character function; no dependencies
package i2a_pkg;

	localparam int VALUE_W        = 64;
	localparam int FUNC_W         = 2;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 4;
	localparam int MAX_DIGITS     = 20;
	localparam int BCD_W          = MAX_DIGITS * DIGIT_W;
	localparam int IDX_W          = $clog2(MAX_DIGITS);
	localparam int VALUE_BITS_DEF = 64;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [CHAR_W-1:0]  CHR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0]  CHR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0]  CHR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0]  CHR_MINUS   = 8'h2d;
	localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;
	localparam logic [DIGIT_W-1:0] DD_LIMIT    = 4'd5;
	localparam logic [DIGIT_W-1:0] DD_ADJUST   = 4'd3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SDEC = 2'd0,
		FUNC_UDEC = 2'd1,
		FUNC_HEXL = 2'd2,
		FUNC_HEXU = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               hex;
		logic               upper;
		logic               neg;
	} entry_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base_chr;
		base_chr = upper ? CHR_UPPER_A : CHR_LOWER_A;
		if (d < DEC_BASE) begin
			return CHR_ZERO + CHAR_W'(d);
		end else begin
			return base_chr + CHAR_W'(d - DEC_BASE);
		end
	endfunction

endpackage

// ===== rtl/integer_to_ascii_converter_top.sv =====
// integer to ascii converter: leading zero digits are skipped, and in signed decimal a minus
// sign is output before the digits of a negative value; receiver cannot stall, one
// character per cycle from the first shown digit to the last
// the back stage takes one item at a time: pop, double dabble for decimal, the sign when
// negative and the digit walk; a two entry queue buffers the front
// asynchronous active low reset empties the queue and idles the back stage
module integer_to_ascii_converter_top import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [VALUE_W-1:0] value,
	input  logic [FUNC_W-1:0] func,
	output logic              strobe,
	output logic [CHAR_W-1:0] char_code,
	output logic              last_char
);

	logic   push;
	entry_t push_entry;
	logic   push_ready;
	logic   pop;
	logic   head_valid;
	entry_t head_entry;

	i2a_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.func       (func),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	i2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	i2a_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.strobe     (strobe),
		.char_code  (char_code),
		.last_char  (last_char)
	);

endmodule

// ===== rtl/i2a_front.sv =====
// front stage: takes a number and mode, masks, finds sign and magnitude
// depends on i2a_pkg
module i2a_front import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	input  logic [FUNC_W-1:0]  func,
	output logic               push,
	output entry_t             push_entry,
	input  logic               push_ready
);

	logic                  valid_s1;
	entry_t                entry_s1;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag_abs;
	logic                  is_neg;
	logic                  take;
	func_t                 mode;
	entry_t                entry_n;

	assign busy = valid_s1 && !push_ready;
	assign take = start && !busy;
	assign push = valid_s1;
	assign push_entry = entry_s1;

	always_comb begin
		mode = func_t'(func);
		raw = value[VALUE_BITS-1:0];
		is_neg = (mode == FUNC_SDEC) && raw[VALUE_BITS-1];
		mag_abs = is_neg ? (~raw + 1'b1) : raw;
		entry_n.mag = VALUE_W'(mag_abs);
		entry_n.hex = (mode == FUNC_HEXL) || (mode == FUNC_HEXU);
		entry_n.upper = (mode == FUNC_HEXU);
		entry_n.neg = is_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= entry_n;
		end
	end

endmodule

// ===== rtl/i2a_queue.sv =====
// two entry queue between front and back stages
// depends on i2a_pkg
module i2a_queue import i2a_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   push_ready,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t            slot0_q;
	entry_t            slot1_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign do_push = push && push_ready;
	assign head_valid = (cnt_q != '0);
	assign head_entry = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_push && !pop) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (pop && !do_push) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (do_push && cnt_q == CNT_W'(1)) begin
				slot0_q <= push_entry;
			end else begin
				slot0_q <= slot1_q;
			end
			if (do_push && cnt_q == CNT_W'(2)) begin
				slot1_q <= push_entry;
			end
		end else if (do_push) begin
			if (cnt_q == '0) begin
				slot0_q <= push_entry;
			end else begin
				slot1_q <= push_entry;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != '0)
		else $error("pop from empty queue");

endmodule

// ===== rtl/i2a_back.sv =====
// back stage: double dabble for decimal, nibble split for hex,
// leading zero skip and character output; depends on i2a_pkg
module i2a_back import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  entry_t            head_entry,
	output logic              pop,
	output logic              strobe,
	output logic [CHAR_W-1:0] char_code,
	output logic              last_char
);

	localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	back_state_t           state_q;
	back_state_t           state_n;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [VALUE_BITS-1:0] sh_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  started_q;
	logic                  neg_q;
	logic                  upper_q;
	logic [DIGIT_W-1:0]    digit;
	logic                  show;
	logic                  emit;
	logic [CHAR_W-1:0]     emit_char;
	logic                  emit_last;
	logic                  strobe_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	assign strobe = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DD_LIMIT) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DD_ADJUST;
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign digit = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
	assign show = started_q || (digit != '0) || (idx_q == '0);

	always_comb begin
		state_n = state_q;
		pop = 1'b0;
		emit = 1'b0;
		emit_char = digit_char(digit, upper_q);
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					state_n = head_entry.hex ? ST_EMIT : ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == '0) begin
					state_n = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				emit = 1'b1;
				emit_char = CHR_MINUS;
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				emit = show;
				emit_last = (idx_q == '0);
				if (idx_q == '0) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe_q <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_n;
			strobe_q <= emit;
			if (pop) begin
				started_q <= 1'b0;
			end else if (state_q == ST_EMIT && show) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		if (pop) begin
			neg_q <= head_entry.neg;
			upper_q <= head_entry.upper;
			idx_q <= IDX_W'(MAX_DIGITS - 1);
			cnt_q <= CNT_W'(VALUE_BITS - 1);
			sh_q <= head_entry.mag[VALUE_BITS-1:0];
			if (head_entry.hex) begin
				bcd_q <= BCD_W'(head_entry.mag[VALUE_BITS-1:0]);
			end else begin
				bcd_q <= '0;
			end
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[VALUE_BITS-1]};
			sh_q <= sh_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end else if (state_q == ST_EMIT && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
			strobe_q && last_q |-> state_q == ST_IDLE)
		else $error("last character while conversion still active");
	assert property (@(posedge clk) disable iff (!arst_n)
			strobe_q && last_q |-> char_q != CHR_MINUS)
		else $error("minus sign flagged as last character");

endmodule
